>>> rtl/rpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_pkg
// Types and constants shared by the signal strength paced LED blinker.
// ----------------------------------------------------------------------------
package rpl_pkg;

    localparam int unsigned NOW_W     = 32;
    localparam int unsigned SLOT_BITS = 3;   // eight pulse slots per cycle

    localparam logic signed [7:0] RSSI_HIGH_DBM = -8'sd30;
    localparam logic signed [7:0] RSSI_LOW_DBM  = -8'sd90;

    localparam logic [9:0] PERIOD_SLOW_MS = 10'd800;
    localparam logic [7:0] PULSE_MIN_MS   = 8'd50;

    // (offset * 650) / 60 for offset 0..60, upper entries padded with the top value
    localparam logic [9:0] SPAN_TBL [64] = '{
        10'd0,   10'd10,  10'd21,  10'd32,  10'd43,  10'd54,
        10'd65,  10'd75,  10'd86,  10'd97,  10'd108, 10'd119,
        10'd130, 10'd140, 10'd151, 10'd162, 10'd173, 10'd184,
        10'd195, 10'd205, 10'd216, 10'd227, 10'd238, 10'd249,
        10'd260, 10'd270, 10'd281, 10'd292, 10'd303, 10'd314,
        10'd325, 10'd335, 10'd346, 10'd357, 10'd368, 10'd379,
        10'd390, 10'd400, 10'd411, 10'd422, 10'd433, 10'd444,
        10'd455, 10'd465, 10'd476, 10'd487, 10'd498, 10'd509,
        10'd520, 10'd530, 10'd541, 10'd552, 10'd563, 10'd574,
        10'd585, 10'd595, 10'd606, 10'd617, 10'd628, 10'd639,
        10'd650, 10'd650, 10'd650, 10'd650
    };

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_TRIPLE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        t_mode            mode;
        logic [8:0]       half;
        logic [7:0]       pulse;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/rpl_tick_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_tick_if
// Tick channel: time, mode and signal strength with valid/ready.
// ----------------------------------------------------------------------------
interface rpl_tick_if;
    logic              valid;
    logic              ready;
    logic [31:0]       now_ms;
    logic [1:0]        mode;
    logic signed [7:0] signal_strength;

    modport source (output valid, output now_ms, output mode, output signal_strength,
                    input ready);
    modport sink   (input valid, input now_ms, input mode, input signal_strength,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/rpl_led_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_led_if
// Result channel: LED pin level and lit flag with valid/ready.
// ----------------------------------------------------------------------------
interface rpl_led_if;
    logic valid;
    logic ready;
    logic led_level;
    logic led_lit;

    modport source (output valid, output led_level, output led_lit, input ready);
    modport sink   (input valid, input led_level, input led_lit, output ready);
endinterface
`default_nettype wire

>>> rtl/rpl_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_cfg_if
// Configuration write channel carrying the active_low register value.
// ----------------------------------------------------------------------------
interface rpl_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rpl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_front
// Accepts ticks, clamps the strength, looks up the period and builds the
// command for the back end.
// ----------------------------------------------------------------------------
module rpl_front (
    rpl_tick_if.sink     i_tick,
    input  wire logic    i_full,
    output logic         o_push,
    output rpl_pkg::t_cmd o_cmd
);
    import rpl_pkg::*;

    logic signed [7:0] clamped;
    logic signed [7:0] diff;
    logic [5:0]        offset;
    logic [9:0]        period;
    logic [7:0]        quarter;

    assign i_tick.ready = !i_full;
    assign o_push       = i_tick.valid && !i_full;

    always_comb begin
        if (i_tick.signal_strength > RSSI_HIGH_DBM) begin
            clamped = RSSI_HIGH_DBM;
        end else if (i_tick.signal_strength < RSSI_LOW_DBM) begin
            clamped = RSSI_LOW_DBM;
        end else begin
            clamped = i_tick.signal_strength;
        end
        diff    = clamped - RSSI_LOW_DBM;
        offset  = diff[5:0];
        period  = PERIOD_SLOW_MS - SPAN_TBL[offset];
        quarter = period[9:2];

        o_cmd.now_ms = i_tick.now_ms;
        o_cmd.half   = period[9:1];
        o_cmd.pulse  = (quarter < PULSE_MIN_MS) ? PULSE_MIN_MS : quarter;
        case (t_mode'(i_tick.mode))
            MODE_SINGLE: o_cmd.mode = MODE_SINGLE;
            MODE_TRIPLE: o_cmd.mode = MODE_TRIPLE;
            default:     o_cmd.mode = MODE_OFF;   // unused code behaves as off
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rpl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rpl_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rpl_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output rpl_pkg::t_cmd      o_cmd
);
    import rpl_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/rpl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpl_back
// Executes commands: off output, single blink state update, triple pulse slot check
// through a bit-serial modulo, and the output register.
// ----------------------------------------------------------------------------
module rpl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rpl_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    input  wire logic          i_active_low,
    output logic               o_pop,
    rpl_led_if.source          o_led
);
    import rpl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SLOT = 3'b100
    } t_back_state;

    t_back_state      r_state, n_state;
    logic [NOW_W-1:0] r_last, n_last;
    logic             r_phase, n_phase;
    logic             r_out_valid, n_out_valid;
    logic             r_level, n_level;
    logic             r_lit, n_lit;
    logic [NOW_W-1:0] r_dvd, n_dvd;
    logic [10:0]      r_rem, n_rem;
    logic [4:0]       r_cnt, n_cnt;
    logic [7:0]       r_pulse, n_pulse;

    logic             out_free;
    logic             lit_v;
    logic [NOW_W-1:0] elapsed;
    logic [10:0]      cycle;
    logic [11:0]      rem_sh;
    logic [10:0]      p1, p2, p3, p4, p5;
    logic             slot_lit;

    assign o_led.valid     = r_out_valid;
    assign o_led.led_level = r_level;
    assign o_led.led_lit   = r_lit;

    always_comb begin
        cycle    = 11'(r_pulse) << SLOT_BITS;
        rem_sh   = {r_rem, r_dvd[NOW_W-1]};
        p1       = 11'(r_pulse);
        p2       = p1 << 1;
        p3       = p2 + p1;
        p4       = p1 << 2;
        p5       = p4 + p1;
        slot_lit = (r_rem < p1) ||
                   ((r_rem >= p2) && (r_rem < p3)) ||
                   ((r_rem >= p4) && (r_rem < p5));
        elapsed  = i_cmd.now_ms - r_last;
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_level     = r_level;
        n_lit       = r_lit;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_pulse     = r_pulse;
        o_pop       = 1'b0;
        lit_v       = 1'b0;

        out_free = !r_out_valid || o_led.ready;
        if (r_out_valid && o_led.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.mode)
                        MODE_SINGLE: begin
                            lit_v = r_phase;
                            if (elapsed >= NOW_W'(i_cmd.half)) begin
                                lit_v   = !r_phase;
                                n_phase = !r_phase;
                                n_last  = i_cmd.now_ms;
                            end
                            n_out_valid = 1'b1;
                            n_lit       = lit_v;
                            n_level     = lit_v ^ i_active_low;
                        end
                        MODE_TRIPLE: begin
                            n_dvd   = i_cmd.now_ms;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_pulse = i_cmd.pulse;
                            n_state = ST_DIV;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_lit       = 1'b0;
                            n_level     = i_active_low;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // one remainder bit per cycle, msb first
                if (rem_sh >= 12'(cycle)) begin
                    n_rem = 11'(rem_sh - 12'(cycle));
                end else begin
                    n_rem = rem_sh[10:0];
                end
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(NOW_W - 1)) begin
                    n_state = ST_SLOT;
                end
            end
            ST_SLOT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_lit       = slot_lit;
                    n_level     = slot_lit ^ i_active_low;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        r_lit   <= n_lit;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_pulse <= n_pulse;
    end

endmodule
`default_nettype wire

>>> rtl/rssi_paced_led_blinker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_paced_led_blinker
// LED blinker paced by received signal strength.
//
// i_tick carries now_ms, mode and signal_strength; each accepted transaction
// yields exactly one o_led transaction with led_level and led_lit, in order.
// i_cfg writes active_low; it is always ready and should be written only
// while no tick is in flight.
// The front end classifies a tick in the accept cycle and pushes a command
// into a QUEUE_DEPTH entry queue; ticks are taken while the queue has room.
// Off and single blink commands pass through the queue to the output register.
// Triple pulse runs a bit-serial 32-bit modulo in the back end, which takes
// no new command until that modulo is done and its result is registered.
// A stalled o_led holds its result; the queue keeps taking ticks until full.
// Reset (synchronous, active low) clears the queue, the blink state, the
// last toggle time and active_low.
// ----------------------------------------------------------------------------
module rssi_paced_led_blinker #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rpl_tick_if.sink  i_tick,
    rpl_cfg_if.sink   i_cfg,
    rpl_led_if.source o_led
);
    import rpl_pkg::*;

    logic r_active_low;
    logic push;
    logic full;
    logic empty;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b0;
        end else if (i_cfg.valid) begin
            r_active_low <= i_cfg.data;
        end
    end

    rpl_front u_front (
        .i_tick (i_tick),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    rpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    rpl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (queue_cmd),
        .i_empty      (empty),
        .i_active_low (r_active_low),
        .o_pop        (pop),
        .o_led        (o_led)
    );

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signal strength paced LED blinker. A table of
// directed ticks covers clamping, time wrap, mode 3 and the triple slot
// edges. Random ticks follow, over phases of sender gaps and receiver stalls,
// with both active_low settings. Every result is compared with a predicted
// LED drive.
// ----------------------------------------------------------------------------
module tb;
    import rpl_pkg::*;

    localparam int          PERIOD_FAST_MS  = 150;
    localparam int unsigned SLOTS_PER_CYCLE = 8;
    localparam logic [1:0]  MODE_UNUSED     = 2'd3;
    localparam int          DIR_ROWS        = 25;
    localparam int          RAND_PER_PHASE  = 375;
    localparam int          NUM_PHASES      = 4;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int          CYCLE_LIMIT     = 500000;

    typedef struct {
        logic [31:0] now_ms;
        logic [1:0]  mode;
        int          strength;
        bit          known;
        logic        led_level;
        logic        led_lit;
    } t_tick_row;

    typedef struct {
        logic led_level;
        logic led_lit;
    } t_led_drive;

    logic i_clk;
    logic i_rst_n;

    rpl_tick_if tick_ch ();
    rpl_cfg_if  cfg_ch ();
    rpl_led_if  led_ch ();

    rssi_paced_led_blinker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .i_cfg   (cfg_ch),
        .o_led   (led_ch)
    );

    // shadow of the block state
    logic [31:0] last_toggle_ms;
    logic        blink_on;
    logic        active_low_reg;

    t_led_drive  pending_leds [$];
    t_led_drive  want;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;

    // expected drive is typed in only where it reads off at a glance
    t_tick_row dir_rows [DIR_ROWS] = '{
        '{32'd0,           MODE_OFF,    0,    1'b1, 1'b0, 1'b0},
        '{32'd0,           MODE_SINGLE, -128, 1'b1, 1'b0, 1'b0},
        '{32'd399,         MODE_SINGLE, -128, 1'b1, 1'b0, 1'b0},
        '{32'd400,         MODE_SINGLE, -128, 1'b1, 1'b1, 1'b1},
        '{32'd474,         MODE_SINGLE, 127,  1'b1, 1'b1, 1'b1},
        '{32'd475,         MODE_SINGLE, 127,  1'b1, 1'b0, 1'b0},
        '{32'd600,         MODE_SINGLE, -30,  1'b0, 1'b0, 1'b0},
        '{32'd700,         MODE_SINGLE, -31,  1'b0, 1'b0, 1'b0},
        '{32'd1000,        MODE_SINGLE, -90,  1'b0, 1'b0, 1'b0},
        '{32'd1100,        MODE_SINGLE, -91,  1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FF00,   MODE_SINGLE, -60,  1'b0, 1'b0, 1'b0},
        '{32'h0000_0010,   MODE_SINGLE, -60,  1'b0, 1'b0, 1'b0},
        '{32'h0000_0020,   MODE_UNUSED, -30,  1'b1, 1'b0, 1'b0},
        '{32'h0000_0020,   MODE_OFF,    127,  1'b1, 1'b0, 1'b0},
        '{32'd0,           MODE_TRIPLE, -128, 1'b1, 1'b1, 1'b1},
        '{32'd200,         MODE_TRIPLE, -128, 1'b1, 1'b0, 1'b0},
        '{32'd400,         MODE_TRIPLE, -90,  1'b1, 1'b1, 1'b1},
        '{32'd999,         MODE_TRIPLE, -90,  1'b1, 1'b1, 1'b1},
        '{32'd1000,        MODE_TRIPLE, -90,  1'b1, 1'b0, 1'b0},
        '{32'd1599,        MODE_TRIPLE, -90,  1'b1, 1'b0, 1'b0},
        '{32'd50,          MODE_TRIPLE, 127,  1'b1, 1'b0, 1'b0},
        '{32'hFFFF_FFFF,   MODE_TRIPLE, -30,  1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF,   MODE_TRIPLE, -60,  1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF,   MODE_SINGLE, 0,    1'b0, 1'b0, 1'b0},
        '{32'd12345,       MODE_TRIPLE, -75,  1'b0, 1'b0, 1'b0}
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic int blink_period_ms(logic signed [7:0] strength);
        int s;
        int offset;
        int span;
        s = strength;
        if (s > int'(RSSI_HIGH_DBM)) s = RSSI_HIGH_DBM;
        if (s < int'(RSSI_LOW_DBM)) s = RSSI_LOW_DBM;
        offset = s - int'(RSSI_LOW_DBM);
        span   = int'(RSSI_HIGH_DBM) - int'(RSSI_LOW_DBM);
        return int'(PERIOD_SLOW_MS) - (offset * (int'(PERIOD_SLOW_MS) - PERIOD_FAST_MS)) / span;
    endfunction

    function automatic t_led_drive predict_led_drive(logic [31:0] now_ms, logic [1:0] mode,
                                                     logic signed [7:0] strength);
        int unsigned half;
        int unsigned pulse;
        int unsigned slot_t;
        logic [31:0] elapsed;
        logic        lit;
        t_led_drive  d;
        lit = 1'b0;
        if (mode == MODE_SINGLE) begin
            half = blink_period_ms(strength) / 2;
            if (half == 0) half = 1;
            elapsed = now_ms - last_toggle_ms;
            if (elapsed >= half) begin
                blink_on       = ~blink_on;
                last_toggle_ms = now_ms;
            end
            lit = blink_on;
        end else if (mode == MODE_TRIPLE) begin
            pulse = blink_period_ms(strength) / 4;
            if (pulse < PULSE_MIN_MS) pulse = PULSE_MIN_MS;
            slot_t = now_ms % (pulse * SLOTS_PER_CYCLE);
            lit = (slot_t < pulse) ||
                  (slot_t >= 2 * pulse && slot_t < 3 * pulse) ||
                  (slot_t >= 4 * pulse && slot_t < 5 * pulse);
        end
        d.led_lit   = lit;
        d.led_level = lit ^ active_low_reg;
        return d;
    endfunction

    // entered just after a falling edge, leaves just after one
    task automatic push_tick(input logic [31:0] now_ms, input logic [1:0] mode,
                             input int strength, input bit known,
                             input logic led_level, input logic led_lit);
        t_led_drive d;
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.now_ms          <= now_ms;
        tick_ch.mode            <= mode;
        tick_ch.signal_strength <= 8'(strength);
        do @(posedge i_clk); while (!tick_ch.ready);
        d = predict_led_drive(now_ms, mode, 8'(strength));
        if (known) begin
            d.led_level = led_level;
            d.led_lit   = led_lit;
        end
        pending_leds.push_back(d);
        @(negedge i_clk);
    endtask

    task automatic write_active_low(input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        active_low_reg = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_leds.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        led_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            led_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && led_ch.valid && led_ch.ready) begin
            if (pending_leds.size() == 0) begin
                $error("unexpected led transaction: led_level %0b led_lit %0b",
                       led_ch.led_level, led_ch.led_lit);
                fail_count++;
            end else begin
                want = pending_leds.pop_front();
                if (led_ch.led_level !== want.led_level) begin
                    $error("led_level: expected %0b, got %0b", want.led_level, led_ch.led_level);
                    fail_count++;
                end
                if (led_ch.led_lit !== want.led_lit) begin
                    $error("led_lit: expected %0b, got %0b", want.led_lit, led_ch.led_lit);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        logic [31:0] time_cursor;
        logic [1:0]  rand_mode;
        int          rand_strength;
        int          pick;
        tick_ch.valid           = 1'b0;
        tick_ch.now_ms          = '0;
        tick_ch.mode            = MODE_OFF;
        tick_ch.signal_strength = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.data             = 1'b0;
        i_rst_n                 = 1'b0;
        last_toggle_ms          = '0;
        blink_on                = 1'b0;
        active_low_reg          = 1'b0;
        time_cursor             = $urandom;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_active_low(1'b0);
        for (int r = 0; r < DIR_ROWS; r++) begin
            push_tick(dir_rows[r].now_ms, dir_rows[r].mode, dir_rows[r].strength,
                      dir_rows[r].known, dir_rows[r].led_level, dir_rows[r].led_lit);
        end
        tick_ch.valid <= 1'b0;
        @(negedge i_clk);
        wait_drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 48; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 48; end
                default: begin send_gap_pct = 36; stall_pct = 36; end
            endcase
            write_active_low(phase % 2 == 0);
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                // hold off until the block has emptied out
                if (phase == 1 && i == RAND_PER_PHASE / 2) begin
                    tick_ch.valid <= 1'b0;
                    @(negedge i_clk);
                    wait_drain();
                end
                // time mostly runs forward so single mode gets to toggle
                pick = $urandom_range(99);
                if (pick < 75)
                    time_cursor = time_cursor + $urandom_range(300);
                else if (pick < 85)
                    time_cursor = time_cursor + $urandom_range(2000, 300);
                else if (pick < 93)
                    time_cursor = $urandom;
                else
                    time_cursor = 32'hFFFF_FFFF - $urandom_range(1000);
                pick = $urandom_range(99);
                if (pick < 45)
                    rand_mode = MODE_SINGLE;
                else if (pick < 85)
                    rand_mode = MODE_TRIPLE;
                else if (pick < 93)
                    rand_mode = MODE_OFF;
                else
                    rand_mode = MODE_UNUSED;
                if ($urandom_range(99) < 70)
                    rand_strength = int'($urandom_range(70)) - 95;
                else
                    rand_strength = int'($urandom_range(255)) - 128;
                push_tick(time_cursor, rand_mode, rand_strength, 1'b0, 1'b0, 1'b0);
            end
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_leds.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rpl_pkg.sv
rtl/rpl_tick_if.sv
rtl/rpl_led_if.sv
rtl/rpl_cfg_if.sv
rtl/rpl_front.sv
rtl/rpl_queue.sv
rtl/rpl_back.sv
rtl/rssi_paced_led_blinker.sv
verif/tb.sv
